FILE: rtl/egd_pkg.sv
// ----------------------------------------------------------------------------
// egd_pkg
// Shared types and register codes for the ElGamal mod-p decryption block.
// ----------------------------------------------------------------------------
package egd_pkg;

    localparam int unsigned FIELD_W     = 32;
    localparam int unsigned CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODULUS     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRIVATE_KEY = 8'd1;

    typedef struct packed {
        logic [FIELD_W-1:0] cipher_first;
        logic [FIELD_W-1:0] cipher_second;
    } t_cipher_in;

    typedef struct packed {
        logic [FIELD_W-1:0] plain_digit;
        logic               key_error;
    } t_plain_out;

endpackage

FILE: rtl/elgamal_decrypt_mod_p.sv
// ----------------------------------------------------------------------------
// elgamal_decrypt_mod_p
// ElGamal decryption over Z_p: plain = c2 * c1^(p-1-key) mod p.
// ----------------------------------------------------------------------------
// One ciphertext pair is taken per beat and one result beat comes back. The
// work runs on a single bit-serial modular multiplier, and each exponent bit
// passes through the dispatch state S_EXP. An item needs one product to
// reduce c1, up to two per bit of the exponent p-1-key (multiply into the
// accumulator, then square), and one final product with c2: at most
// (2*MOD_WIDTH + 2) products, fewer for exponents with leading zeros. A key
// above p-1 or a zero modulus returns at once with key_error set and a zero
// digit. The input stalls while an item is in work; a finished result waits
// in the output register while the next item is taken. Configuration must be
// written only while the block is idle; the block itself does not enforce it.
module elgamal_decrypt_mod_p
    import egd_pkg::*;
#(
    parameter int unsigned MOD_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [FIELD_W-1:0]     i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_cipher_in             i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_plain_out             o_out_data
);

    localparam int unsigned W = MOD_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_EXP,
        S_MACC,
        S_MSQ,
        S_FIN,
        S_DONE
    } t_state;

    t_state     r_state;
    logic [W-1:0] r_modulus;
    logic [W-1:0] r_key;
    logic [W-1:0] r_c2;
    logic [W-1:0] r_e;
    logic [W-1:0] r_acc;
    logic [W-1:0] r_sq;
    logic [W-1:0] r_res;
    logic         r_err;
    logic         r_mul_start;
    logic [W-1:0] r_mul_a;
    logic [W-1:0] r_mul_b;
    logic         r_out_valid;
    t_plain_out   r_out_data;

    logic         mul_done;
    logic [W-1:0] mul_result;
    logic         in_accept;
    logic         out_free;
    logic [W-1:0] c1_in;

    egd_mulmod #(
        .WIDTH (W)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mul_start),
        .i_a      (r_mul_a),
        .i_b      (r_mul_b),
        .i_m      (r_modulus),
        .o_done   (mul_done),
        .o_result (mul_result)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign c1_in       = i_in_data.cipher_first[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_modulus   <= W'(2);
            r_key       <= '0;
            r_mul_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MODULUS:     r_modulus <= i_cfg_data[W-1:0];
                    CFG_PRIVATE_KEY: r_key     <= i_cfg_data[W-1:0];
                    default: ;
                endcase
            end

            // a waiting result is refilled from S_DONE in the same cycle
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_mul_start <= in_accept && (r_key < r_modulus) &&
                                   (r_modulus != W'(1));
                    if (in_accept) begin
                        r_c2 <= i_in_data.cipher_second[W-1:0];
                        if (r_key >= r_modulus) begin
                            // key too large, or zero modulus
                            r_res   <= '0;
                            r_err   <= 1'b1;
                            r_state <= S_DONE;
                        end else if (r_modulus == W'(1)) begin
                            r_res   <= '0;
                            r_err   <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            // reduce c1 as 1 * c1 mod p
                            r_e         <= r_modulus - 1'b1 - r_key;
                            r_acc       <= W'(1);
                            r_mul_a     <= W'(1);
                            r_mul_b     <= c1_in;
                            r_state     <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    r_mul_start <= 1'b0;
                    if (mul_done) begin
                        r_sq    <= mul_result;
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    r_mul_start <= 1'b1;
                    if (r_e == '0) begin
                        // c2 is reduced inside the final product
                        r_mul_a <= r_acc;
                        r_mul_b <= r_c2;
                        r_state <= S_FIN;
                    end else if (r_e[0]) begin
                        r_mul_a <= r_acc;
                        r_mul_b <= r_sq;
                        r_state <= S_MACC;
                    end else begin
                        r_mul_a <= r_sq;
                        r_mul_b <= r_sq;
                        r_state <= S_MSQ;
                    end
                end
                S_MACC: begin
                    r_mul_start <= mul_done;
                    if (mul_done) begin
                        r_acc       <= mul_result;
                        r_mul_a     <= r_sq;
                        r_mul_b     <= r_sq;
                        r_state     <= S_MSQ;
                    end
                end
                S_MSQ: begin
                    r_mul_start <= 1'b0;
                    if (mul_done) begin
                        r_sq    <= mul_result;
                        r_e     <= r_e >> 1;
                        r_state <= S_EXP;
                    end
                end
                S_FIN: begin
                    r_mul_start <= 1'b0;
                    if (mul_done) begin
                        r_res   <= mul_result;
                        r_err   <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_mul_start <= 1'b0;
                    // hold until the output register can take the beat
                    if (out_free) begin
                        r_out_valid            <= 1'b1;
                        r_out_data.plain_digit <= FIELD_W'(r_res);
                        r_out_data.key_error   <= r_err;
                        r_state                <= S_IDLE;
                    end
                end
                default: begin
                    r_mul_start <= 1'b0;
                    r_state     <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: rtl/egd_mulmod.sv
// ----------------------------------------------------------------------------
// egd_mulmod
// Bit-serial modular multiplier: result = a * b mod m, one bit of b per cycle,
// most significant bit first. Requires a < m; b may be any WIDTH-bit value.
// ----------------------------------------------------------------------------
module egd_mulmod #(
    parameter int unsigned WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic [WIDTH-1:0] i_m,
    output logic             o_done,
    output logic [WIDTH-1:0] o_result
);

    localparam int unsigned CNT_W = $clog2(WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;

    logic [WIDTH:0]   dbl;
    logic [WIDTH-1:0] dbl_red;
    logic [WIDTH:0]   sum;
    logic [WIDTH-1:0] n_acc;

    // double, reduce once; then add a if the current bit is set, reduce once
    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, i_m}) ? WIDTH'(dbl - {1'b0, i_m}) : dbl[WIDTH-1:0];
        sum     = {1'b0, dbl_red} + (r_b[WIDTH-1] ? {1'b0, r_a} : '0);
        n_acc   = (sum >= {1'b0, i_m}) ? WIDTH'(sum - {1'b0, i_m}) : sum[WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= CNT_W'(WIDTH - 1);
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
            end else if (r_busy) begin
                r_acc  <= n_acc;
                r_b    <= {r_b[WIDTH-2:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == '0);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ElGamal mod-p decryption block.
// ----------------------------------------------------------------------------
// Ciphertext pairs are queued by the stimulus process and presented by a
// driver on the falling edge. Each accepted beat is run through a local
// square-and-multiply model, using the current register settings, and the
// resulting digit and error flag are queued. The monitor pops and compares
// one entry per accepted result beat. Registers are rewritten only after the
// block has drained. A directed part covers the unusable moduli, the key
// bounds, unreduced components and ignored register indexes. Random phases
// with mixed moduli and keys follow, under four sender and receiver idle
// patterns.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import egd_pkg::*;

    localparam int unsigned MOD_W           = 32;
    localparam int unsigned NUM_PHASES      = 12;
    localparam int unsigned ITEMS_PER_PHASE = 21;
    localparam int unsigned TAIL_CYCLES     = 2500;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 8'hFF;

    localparam logic [FIELD_W-1:0] PRIME_TOP = 32'hFFFF_FFFB;
    localparam logic [FIELD_W-1:0] PRIME_M31 = 32'h7FFF_FFFF;

    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [FIELD_W-1:0]     cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    t_cipher_in             in_beat   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    t_plain_out             out_beat;

    t_cipher_in cipher_queue[$];
    t_plain_out plain_queue[$];

    logic [FIELD_W-1:0] modulus_reg    = 32'd2;
    logic [FIELD_W-1:0] key_reg        = 32'd0;
    logic               beat_taken     = 1'b0;
    int unsigned        send_idle_pct  = 0;
    int unsigned        recv_stall_pct = 0;
    int unsigned        mismatch_count = 0;

    elgamal_decrypt_mod_p #(
        .MOD_WIDTH(MOD_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_beat)
    );

    always #6 i_clk = ~i_clk;

    // c2 * c1^(p-1-k) mod p, exponent scanned from the low bit up
    function automatic t_plain_out decrypt_digit(t_cipher_in beat,
                                                 logic [FIELD_W-1:0] p_in,
                                                 logic [FIELD_W-1:0] k_in);
        longint unsigned width_mask;
        longint unsigned p;
        longint unsigned k;
        longint unsigned expo;
        longint unsigned acc;
        longint unsigned sq;
        t_plain_out      res;
        width_mask = (64'd1 << MOD_W) - 1;
        p   = p_in & width_mask;
        k   = k_in & width_mask;
        res = '0;
        if (p == 0 || k > p - 1) begin
            res.key_error = 1'b1;
            return res;
        end
        expo = p - 1 - k;
        acc  = 1 % p;
        sq   = (beat.cipher_first & width_mask) % p;
        while (expo != 0) begin
            if ((expo & 1) != 0)
                acc = (acc * sq) % p;
            sq   = (sq * sq) % p;
            expo = expo >> 1;
        end
        acc = (((beat.cipher_second & width_mask) % p) * acc) % p;
        res.plain_digit = acc[FIELD_W-1:0];
        return res;
    endfunction

    function automatic logic [FIELD_W-1:0] pick_modulus();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return $urandom_range(255, 2);
            5, 6:          return $urandom_range(65535, 256);
            7:             return PRIME_TOP;
            8:             return PRIME_M31;
            default:       return $urandom;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                 input logic [FIELD_W-1:0] want);
        $display("%0t ns: %s mismatch, got 0x%08h, want 0x%08h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_cipher(input logic [FIELD_W-1:0] c1, input logic [FIELD_W-1:0] c2);
        t_cipher_in beat;
        beat.cipher_first  = c1;
        beat.cipher_second = c2;
        cipher_queue = {cipher_queue, beat};
    endtask

    task automatic drain();
        while (cipher_queue.size() != 0 || plain_queue.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [FIELD_W-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        if (idx == CFG_MODULUS)
            modulus_reg = val;
        else if (idx == CFG_PRIVATE_KEY)
            key_reg = val;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_config(input logic [FIELD_W-1:0] p, input logic [FIELD_W-1:0] k);
        write_reg(CFG_MODULUS, p);
        write_reg(CFG_PRIVATE_KEY, k);
    endtask

    // Driver: take the beat and its expectation on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && !in_stall) begin
            plain_queue = {plain_queue, decrypt_digit(in_beat, modulus_reg, key_reg)};
            void'(cipher_queue.pop_front());
            beat_taken = 1'b1;
        end
    end

    // Driver: hold a pending beat, otherwise present the next one or idle
    always @(negedge i_clk) begin
        if (!in_valid || beat_taken) begin
            if (i_rst_n && cipher_queue.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_beat  <= cipher_queue[0];
            end else begin
                in_valid <= 1'b0;
            end
        end
        beat_taken = 1'b0;
    end

    // Monitor
    always @(posedge i_clk) begin
        t_plain_out want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (plain_queue.size() == 0) begin
                flag_mismatch("unexpected beat, plain_digit", out_beat.plain_digit, '0);
            end else begin
                want = plain_queue.pop_front();
                if (out_beat.plain_digit !== want.plain_digit)
                    flag_mismatch("plain_digit", out_beat.plain_digit, want.plain_digit);
                if (out_beat.key_error !== want.key_error)
                    flag_mismatch("key_error", FIELD_W'(out_beat.key_error),
                                  FIELD_W'(want.key_error));
            end
        end
    end

    always @(negedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        int unsigned        phase;
        int unsigned        n;
        logic [FIELD_W-1:0] p;
        logic [FIELD_W-1:0] k;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: p = 2, k = 0
        send_cipher('0, '0);
        send_cipher('1, '1);
        send_cipher(32'd3, 32'd5);
        drain();

        // zero modulus is unusable
        apply_config(32'd0, 32'd0);
        send_cipher(32'd7, 32'd9);
        drain();

        // modulus one: key zero works, any other key is too large
        apply_config(32'd1, 32'd0);
        send_cipher(32'd7, 32'd9);
        drain();
        write_reg(CFG_PRIVATE_KEY, 32'd1);
        send_cipher(32'd7, 32'd9);
        drain();

        // small group, generator 5, key 6: (10, 9) carries digit 13
        apply_config(32'd23, 32'd6);
        send_cipher(32'd10, 32'd9);
        send_cipher(32'd0, 32'd22);
        drain();

        // largest 32-bit prime, unreduced components and a zero base
        apply_config(PRIME_TOP, 32'd0);
        send_cipher('1, '1);
        send_cipher(32'd0, 32'd1);
        drain();
        // key p-1 gives a zero exponent, so a zero base still yields one
        write_reg(CFG_PRIVATE_KEY, PRIME_TOP - 32'd1);
        send_cipher(32'd0, 32'd12345);
        drain();
        write_reg(CFG_PRIVATE_KEY, PRIME_TOP);
        send_cipher(32'd2, 32'd3);
        drain();
        write_reg(CFG_PRIVATE_KEY, '1);
        send_cipher(32'd2, 32'd3);
        drain();

        // composite modulus at the top of the range
        apply_config('1, 32'd12345);
        send_cipher(32'hDEAD_BEEF, 32'h1234_5678);
        send_cipher('1, 32'h8000_0000);
        drain();

        // writes to unused indexes leave the settings alone
        write_reg(CFG_SPARE_LO, 32'd99);
        write_reg(CFG_SPARE_HI, 32'd0);
        send_cipher(32'h0F0F_0F0F, 32'hF0F0_F0F0);
        drain();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 52;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 52;
                end
                default: begin
                    send_idle_pct  = 8;
                    recv_stall_pct = 8;
                end
            endcase
            p = pick_modulus();
            if ($urandom_range(4) != 0)
                k = $urandom_range(p - 1, 0);
            else
                k = $urandom;
            apply_config(p, k);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // pause halfway until every result is back
                if (n == ITEMS_PER_PHASE / 2)
                    drain();
                if ($urandom_range(3) == 0)
                    send_cipher($urandom % p, $urandom % p);
                else
                    send_cipher($urandom, $urandom);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #(60_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
